// File: hw/rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int BYTE_W     = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LENGTH,
		REG_REPLACEMENT_BYTES,
		REG_REPLACEMENT_LENGTH
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic              out_last;
	} res_t;

endpackage

// File: hw/rtl/sfr_if.sv
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output out_valid, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input out_valid, input out_last,
		output ready);
endinterface

// File: hw/rtl/sfr_cell.sv
module sfr_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] d,
	input  logic [7:0] expect_byte,
	output logic [7:0] q,
	output logic       eq
);
	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q  = byte_q;
	// compare against the byte entering this cell
	assign eq = (d == expect_byte);
endmodule

// File: hw/rtl/sfr_window.sv
module sfr_window #(
	parameter int MAX_LEN = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     in_byte,
	input  logic                           in_last,
	input  logic [8*MAX_LEN-1:0]           pattern,
	input  logic [$clog2(MAX_LEN+1)-1:0]   plen,
	input  logic [8*MAX_LEN-1:0]           repl,
	input  logic [$clog2(MAX_LEN+1)-1:0]   rlen,
	output sfr_pkg::res_t                  res [MAX_LEN],
	output logic [$clog2(MAX_LEN+1)-1:0]   res_cnt
);
	import sfr_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [7:0]         chain_d  [MAX_LEN];
	logic [7:0]         chain_q  [MAX_LEN];
	logic [7:0]         expect_b [MAX_LEN];
	logic [MAX_LEN-1:0] eq;
	logic [MAX_LEN-1:0] care;

	logic [LW-1:0] fill_q;
	logic [LW-1:0] fill_kept;
	logic [LW-1:0] fill_new;
	logic [LW-1:0] n_data;
	logic          full;
	logic          match;
	logic          marker;

	// window held newest first: cell 0 takes the incoming byte
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic [LW-1:0] tap;

		if (k == 0) begin : g_head
			assign chain_d[k] = in_byte;
		end else begin : g_body
			assign chain_d[k] = chain_q[k-1];
		end

		assign tap         = plen - LW'(1) - LW'(k);
		assign care[k]     = LW'(k) < plen;
		assign expect_b[k] = pattern[8*tap[IW-1:0] +: 8];

		sfr_cell u_cell (
			.clk        (clk),
			.shift_en   (accept),
			.d          (chain_d[k]),
			.expect_byte(expect_b[k]),
			.q          (chain_q[k]),
			.eq         (eq[k])
		);
	end

	assign fill_kept = (fill_q >= plen) ? (plen - LW'(1)) : fill_q;
	assign fill_new  = fill_kept + LW'(1);
	assign full      = (fill_new == plen);
	assign match     = full && ((eq | ~care) == {MAX_LEN{1'b1}});

	always_comb begin
		if (match) begin
			n_data = rlen;
		end else if (in_last) begin
			n_data = fill_new;
		end else if (full) begin
			n_data = LW'(1);
		end else begin
			n_data = '0;
		end
	end

	assign marker  = in_last && (n_data == '0);
	assign res_cnt = marker ? LW'(1) : n_data;

	for (genvar j = 0; j < MAX_LEN; j++) begin : g_res
		logic [LW-1:0] sel;

		assign sel = fill_new - LW'(1) - LW'(j);

		always_comb begin
			if (marker) begin
				res[j].out_byte  = '0;
				res[j].out_valid = 1'b0;
				res[j].out_last  = 1'b1;
			end else begin
				res[j].out_byte  = match ? repl[8*j +: 8] : chain_d[sel[IW-1:0]];
				res[j].out_valid = 1'b1;
				res[j].out_last  = in_last && (LW'(j) == n_data - LW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (match || in_last) begin
				fill_q <= '0;
			end else if (full) begin
				fill_q <= plen - LW'(1);
			end else begin
				fill_q <= fill_new;
			end
		end
	end
endmodule

// File: hw/rtl/sfr_outq.sv
module sfr_outq #(
	parameter int MAX_LEN = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  sfr_pkg::res_t                res [MAX_LEN],
	input  logic [$clog2(MAX_LEN+1)-1:0] res_cnt,
	output logic                         room,
	sfr_out_if.source                    out_ch
);
	import sfr_pkg::*;

	localparam int QD = 2 * MAX_LEN;
	localparam int CW = $clog2(QD + 1);
	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	res_t          entry_q [QD];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] base;
	logic          pop;

	assign pop  = out_ch.valid && out_ch.ready;
	assign base = cnt_q - CW'(pop);
	assign room = cnt_q <= CW'(MAX_LEN);

	for (genvar i = 0; i < QD; i++) begin : g_entry
		res_t          shifted;
		logic [CW-1:0] off;

		if (i < QD - 1) begin : g_mid
			assign shifted = pop ? entry_q[i+1] : entry_q[i];
		end else begin : g_tail
			assign shifted = entry_q[i];
		end

		assign off = CW'(i) - base;

		always_ff @(posedge clk) begin
			if (CW'(i) < base) begin
				entry_q[i] <= shifted;
			end else if (off < CW'(MAX_LEN)) begin
				entry_q[i] <= res[off[IW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + (push ? CW'(res_cnt) : CW'(0));
		end
	end

	assign out_ch.valid     = (cnt_q != '0);
	assign out_ch.out_byte  = entry_q[0].out_byte;
	assign out_ch.out_valid = entry_q[0].out_valid;
	assign out_ch.out_last  = entry_q[0].out_last;
endmodule

// File: hw/rtl/stream_find_replace.sv
// Streaming find-and-replace over a byte stream.
// in_ch carries one text byte per word with in_last on the final byte of a
// stream; out_ch carries result words: a byte with out_valid set, or on a
// stream that ends with nothing left to send, one word with out_valid clear.
// out_last is set on the final result word of each stream.
// Pattern, its length, the replacement and its length are written through
// the cfg_we / cfg_index / cfg_data port; the user must write them only
// while the block is idle, which the block itself does not enforce. The
// window is a row of MAX_LEN byte cells compared in parallel with the
// pattern; an accepted word yields up to MAX_LEN result words, which go into
// a result queue of 2*MAX_LEN entries and are offered on out_ch from its
// head. The block takes one byte per cycle while each byte yields at most
// one result; the queue drains one result word per cycle while out_ch.ready
// is high, and in_ch.ready drops while more than MAX_LEN words are queued.
// A stalled receiver fills the queue and then holds off the input; no word
// is dropped. Reset empties the window and the queue and sets the pattern
// length to one and the replacement length to zero.
module stream_find_replace #(
	parameter int MAX_LEN = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	sfr_in_if.sink                           in_ch,
	sfr_out_if.source                        out_ch
);
	import sfr_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);

	logic [8*MAX_LEN-1:0] pattern_q;
	logic [8*MAX_LEN-1:0] repl_q;
	logic [LW-1:0]        plen_q;
	logic [LW-1:0]        rlen_q;
	logic [3:0]           len_raw;

	res_t          res [MAX_LEN];
	logic [LW-1:0] res_cnt;
	logic          room;
	logic          accept;

	assign len_raw = cfg_data[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			repl_q    <= '0;
			plen_q    <= LW'(1);
			rlen_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES: begin
					pattern_q <= cfg_data[8*MAX_LEN-1:0];
				end
				REG_PATTERN_LENGTH: begin
					if (len_raw == 4'd0) begin
						plen_q <= LW'(1);
					end else if (len_raw > 4'(MAX_LEN)) begin
						plen_q <= LW'(MAX_LEN);
					end else begin
						plen_q <= LW'(len_raw);
					end
				end
				REG_REPLACEMENT_BYTES: begin
					repl_q <= cfg_data[8*MAX_LEN-1:0];
				end
				REG_REPLACEMENT_LENGTH: begin
					if (len_raw > 4'(MAX_LEN)) begin
						rlen_q <= LW'(MAX_LEN);
					end else begin
						rlen_q <= LW'(len_raw);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && room;

	sfr_window #(
		.MAX_LEN(MAX_LEN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_byte(in_ch.in_byte),
		.in_last(in_ch.in_last),
		.pattern(pattern_q),
		.plen   (plen_q),
		.repl   (repl_q),
		.rlen   (rlen_q),
		.res    (res),
		.res_cnt(res_cnt)
	);

	sfr_outq #(
		.MAX_LEN(MAX_LEN)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.res    (res),
		.res_cnt(res_cnt),
		.room   (room),
		.out_ch (out_ch)
	);
endmodule
